>>> hw/rtl/sblf_pkg.sv
// sblf_pkg: shared constants, register indices, mode codes and inter-module structs
// for the selective blur luma filter; no dependencies
package sblf_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_HEIGHT   = 4096;
  localparam int PIX_W        = 8;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int FILL_W       = $clog2(MAX_WIDTH + 2);
  localparam int MODE_W       = 3;
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int LINE_W       = 2 * PIX_W;
  localparam int OQ_DEPTH     = 8;
  localparam int OQ_PTR_W     = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W     = $clog2(OQ_DEPTH + 1);
  localparam int FLIGHT_W     = 2;

  // reset values of the registers, sizes given as pixel and line counts
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;
  localparam int THR_RESET    = 1;

  // truncating divide by reciprocal: x/3 for x <= 765, x/9 for x <= 2295
  localparam int DIV3_MUL     = 683;
  localparam int DIV3_SHIFT   = 11;
  localparam int DIV9_MUL     = 7282;
  localparam int DIV9_SHIFT   = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE         = 2'd0,
    REG_THRESHOLD    = 2'd1,
    REG_FRAME_WIDTH  = 2'd2,
    REG_FRAME_HEIGHT = 2'd3
  } reg_idx_e;

  localparam logic [MODE_W-1:0] MODE_MEAN   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_THRESH = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SELECT = 3'd2;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // one pixel position pushed into the line memory and window
  typedef struct packed {
    logic             valid;
    logic             emit;
    logic [PIX_W-1:0] pix;
    logic             col_edge;
    logic             row_edge;
    logic             eof;
    logic [COL_W-1:0] addr;
  } push_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PIX_W-1:0]  thr;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [COL_W-1:0]  addr;
    logic [LINE_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic             valid;
    logic             eof;
    logic [PIX_W-1:0] pix;
  } result_t;

endpackage

>>> hw/rtl/selective_blur_luma_filter_unit.sv
// selective_blur_luma_filter_unit: top level of the selective blur luma filter
// depends on sblf_pkg, sblf_ctrl, sblf_filter, sblf_outq, sblf_ram
//
// Takes one 8-bit luma pixel per clock in raster order and returns the filtered frame
// in the same order, one pixel per clock sustained. A pixel transfer is followed by its
// result once the pipeline holds frame_width+1 positions; until then pixels only fill
// the line memory. The rate is set by the line memory, a single 2048 x 16 ram holding
// the row above and the current row per column, read once and written once per pixel.
// Flush transfers (tuser high) push zero pixels to drain the pixels still held; they are
// dropped when nothing is pending, and when the last real pixel leaves the raster
// restarts at the top left. The input stalls only when the eight-entry result queue
// would overflow under output back-pressure. The line memory needs no clearing after
// reset. Users must write registers only while the block is idle (not enforced here);
// writing frame_width or frame_height discards pending pixels and restarts the frame.
module selective_blur_luma_filter_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [sblf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sblf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [7:0] pixel_in
  input  logic                            s_axis_tuser,   // [0] command (1 = flush)
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,   // [7:0] pixel_out
  output logic                            m_axis_tlast    // end_of_frame
);

  sblf_pkg::push_t                   push;
  sblf_pkg::cfg_t                    cfg;
  sblf_pkg::ram_wr_t                 wr;
  sblf_pkg::result_t                 res;
  logic [sblf_pkg::LINE_W-1:0]       rd_data;
  logic [sblf_pkg::FLIGHT_W-1:0]     inflight;
  logic [sblf_pkg::OQ_CNT_W-1:0]     oq_count;
  logic [sblf_pkg::OQ_CNT_W:0]       committed;
  logic                              acc;

  // every result in flight already owns a queue slot
  assign committed     = {1'b0, oq_count} + (sblf_pkg::OQ_CNT_W + 1)'(inflight);
  assign s_axis_tready = committed < (sblf_pkg::OQ_CNT_W + 1)'(sblf_pkg::OQ_DEPTH);
  assign acc           = s_axis_tvalid && s_axis_tready;

  // raster and fill bookkeeping, decided in the transfer cycle
  sblf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .acc_i       (acc),
    .cmd_i       (s_axis_tuser),
    .pix_i       (s_axis_tdata),
    .push_o      (push),
    .cfg_o       (cfg)
  );

  // line memory: {row above, current row} per column
  sblf_ram #(
    .WIDTH (sblf_pkg::LINE_W),
    .DEPTH (sblf_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (push.valid),
    .raddr_i (push.addr),
    .rdata_o (rd_data)
  );

  // window update and filter arithmetic, fixed latency
  sblf_filter u_filter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .rd_data_i  (rd_data),
    .cfg_i      (cfg),
    .wr_o       (wr),
    .res_o      (res),
    .inflight_o (inflight)
  );

  // result queue towards the output stream
  sblf_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res),
    .pop_i   (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .pix_o   (m_axis_tdata),
    .eof_o   (m_axis_tlast),
    .count_o (oq_count)
  );

endmodule

>>> hw/rtl/sblf_ram.sv
// sblf_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module sblf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first: a read of the address being written returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/sblf_ctrl.sv
// sblf_ctrl: configuration registers, raster position and pipeline fill tracking
// depends on sblf_pkg
module sblf_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sblf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sblf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               acc_i,
  input  logic                               cmd_i,
  input  logic [sblf_pkg::PIX_W-1:0]         pix_i,
  output sblf_pkg::push_t                    push_o,
  output sblf_pkg::cfg_t                     cfg_o
);

  logic [sblf_pkg::MODE_W-1:0] mode_q, mode_d;
  logic [sblf_pkg::PIX_W-1:0]  thr_q, thr_d;
  logic [sblf_pkg::COL_W-1:0]  w_last_q, w_last_d;
  logic [sblf_pkg::ROW_W-1:0]  h_last_q, h_last_d;
  logic [sblf_pkg::COL_W-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [sblf_pkg::ROW_W-1:0]  in_row_q, in_row_d, out_row_q, out_row_d;
  logic [sblf_pkg::FILL_W-1:0] fill_q, fill_d, live_q, live_d, live_dec;
  logic [sblf_pkg::WIDTH_REG_W-1:0]  w_req;
  logic [sblf_pkg::HEIGHT_REG_W-1:0] h_req;
  logic is_pix, push, emit, restart;

  assign is_pix = (cmd_i == sblf_pkg::CMD_PIXEL);
  assign push   = acc_i && (is_pix || (live_q != '0));
  assign emit   = fill_q > (sblf_pkg::FILL_W'(w_last_q) + sblf_pkg::FILL_W'(1));
  assign w_req  = cfg_data_i[sblf_pkg::WIDTH_REG_W-1:0];
  assign h_req  = cfg_data_i[sblf_pkg::HEIGHT_REG_W-1:0];

  always_comb begin
    mode_d    = mode_q;
    thr_d     = thr_q;
    w_last_d  = w_last_q;
    h_last_d  = h_last_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    fill_d    = fill_q;
    live_d    = live_q;
    live_dec  = (live_q != '0) ? live_q - sblf_pkg::FILL_W'(1) : '0;
    restart   = 1'b0;

    if (push) begin
      if (in_col_q == w_last_q) begin
        in_col_d = '0;
        in_row_d = (in_row_q == h_last_q) ? '0 : in_row_q + sblf_pkg::ROW_W'(1);
      end else begin
        in_col_d = in_col_q + sblf_pkg::COL_W'(1);
      end
      if (!emit) begin
        fill_d = fill_q + sblf_pkg::FILL_W'(1);
      end
      if (is_pix) begin
        live_d = emit ? fill_q : fill_q + sblf_pkg::FILL_W'(1);
      end
      if (emit) begin
        if (out_col_q == w_last_q) begin
          out_col_d = '0;
          out_row_d = (out_row_q == h_last_q) ? '0 : out_row_q + sblf_pkg::ROW_W'(1);
        end else begin
          out_col_d = out_col_q + sblf_pkg::COL_W'(1);
        end
        // flush that outputs the last real pixel starts a new frame
        if (!is_pix) begin
          live_d  = live_dec;
          restart = (live_dec == '0);
        end
      end
    end

    if (cfg_we_i) begin
      case (cfg_index_i)
        sblf_pkg::REG_MODE: begin
          mode_d = cfg_data_i[sblf_pkg::MODE_W-1:0];
        end
        sblf_pkg::REG_THRESHOLD: begin
          thr_d = cfg_data_i[sblf_pkg::PIX_W-1:0];
        end
        sblf_pkg::REG_FRAME_WIDTH: begin
          if (w_req < sblf_pkg::WIDTH_REG_W'(3)) begin
            w_last_d = sblf_pkg::COL_W'(2);
          end else if (int'(w_req) > sblf_pkg::MAX_WIDTH) begin
            w_last_d = sblf_pkg::COL_W'(sblf_pkg::MAX_WIDTH - 1);
          end else begin
            w_last_d = sblf_pkg::COL_W'(w_req - sblf_pkg::WIDTH_REG_W'(1));
          end
          restart = 1'b1;
        end
        sblf_pkg::REG_FRAME_HEIGHT: begin
          if (h_req == '0) begin
            h_last_d = '0;
          end else if (int'(h_req) > sblf_pkg::MAX_HEIGHT) begin
            h_last_d = sblf_pkg::ROW_W'(sblf_pkg::MAX_HEIGHT - 1);
          end else begin
            h_last_d = sblf_pkg::ROW_W'(h_req - sblf_pkg::HEIGHT_REG_W'(1));
          end
          restart = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (restart) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      fill_d    = '0;
      live_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= sblf_pkg::MODE_MEAN;
      thr_q     <= sblf_pkg::PIX_W'(sblf_pkg::THR_RESET);
      w_last_q  <= sblf_pkg::COL_W'(sblf_pkg::WIDTH_RESET - 1);
      h_last_q  <= sblf_pkg::ROW_W'(sblf_pkg::HEIGHT_RESET - 1);
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      fill_q    <= '0;
      live_q    <= '0;
    end else begin
      mode_q    <= mode_d;
      thr_q     <= thr_d;
      w_last_q  <= w_last_d;
      h_last_q  <= h_last_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      fill_q    <= fill_d;
      live_q    <= live_d;
    end
  end

  always_comb begin
    push_o.valid    = push;
    push_o.emit     = emit;
    push_o.pix      = is_pix ? pix_i : '0;
    push_o.col_edge = (out_col_q == '0) || (out_col_q == w_last_q);
    push_o.row_edge = (out_row_q == '0) || (out_row_q == h_last_q);
    push_o.eof      = (out_col_q == w_last_q) && (out_row_q == h_last_q);
    push_o.addr     = in_col_q;
  end

  assign cfg_o.mode = mode_q;
  assign cfg_o.thr  = thr_q;

endmodule

>>> hw/rtl/sblf_filter.sv
// sblf_filter: line memory write-back with forwarding, 3x3 window and filter arithmetic
// depends on sblf_pkg
module sblf_filter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sblf_pkg::push_t                   push_i,
  input  logic [sblf_pkg::LINE_W-1:0]       rd_data_i,
  input  sblf_pkg::cfg_t                    cfg_i,
  output sblf_pkg::ram_wr_t                 wr_o,
  output sblf_pkg::result_t                 res_o,
  output logic [sblf_pkg::FLIGHT_W-1:0]     inflight_o
);

  sblf_pkg::push_t             s1_q;
  logic                        fwd_hit_q;
  logic [sblf_pkg::LINE_W-1:0] fwd_data_q;
  logic [sblf_pkg::LINE_W-1:0] entry;
  logic [sblf_pkg::PIX_W-1:0]  above, cur;
  logic [sblf_pkg::PIX_W-1:0]  win_q [3][3];

  logic                        s2_valid_q, s2_col_edge_q, s2_row_edge_q, s2_eof_q;
  logic                        s3_valid_q, s3_col_edge_q, s3_row_edge_q, s3_eof_q;
  logic [sblf_pkg::PIX_W-1:0]  s3_c_q;
  logic [9:0]                  s3_sum3_q, sum3;
  logic [11:0]                 s3_sum9_q, sum9;
  logic [sblf_pkg::PIX_W:0]    lim_wide;
  logic [sblf_pkg::PIX_W-1:0]  lim, c2;
  logic [sblf_pkg::PIX_W-1:0]  clip [3][3];
  logic [9:0]                  row_sum [3];
  logic [20:0]                 prod3;
  logic [24:0]                 prod9;
  logic [sblf_pkg::PIX_W-1:0]  mean, div9, res_pix;

  // stage 1: line memory word arrives, forward a write made at the read edge
  assign entry = fwd_hit_q ? fwd_data_q : rd_data_i;
  assign above = entry[sblf_pkg::LINE_W-1:sblf_pkg::PIX_W];
  assign cur   = entry[sblf_pkg::PIX_W-1:0];

  assign wr_o.we   = s1_q.valid;
  assign wr_o.addr = s1_q.addr;
  assign wr_o.data = {cur, s1_q.pix};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q       <= '0;
      fwd_hit_q  <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else begin
      s1_q       <= push_i;
      fwd_hit_q  <= push_i.valid && s1_q.valid && (push_i.addr == s1_q.addr);
      s2_valid_q <= s1_q.valid && s1_q.emit;
      s3_valid_q <= s2_valid_q;
      if (s1_q.valid) begin
        for (int i = 0; i < 3; i++) begin
          win_q[i][0] <= win_q[i][1];
          win_q[i][1] <= win_q[i][2];
        end
        win_q[0][2] <= above;
        win_q[1][2] <= cur;
        win_q[2][2] <= s1_q.pix;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q    <= wr_o.data;
    s2_col_edge_q <= s1_q.col_edge;
    s2_row_edge_q <= s1_q.row_edge;
    s2_eof_q      <= s1_q.eof;
    s3_col_edge_q <= s2_col_edge_q;
    s3_row_edge_q <= s2_row_edge_q;
    s3_eof_q      <= s2_eof_q;
    s3_c_q        <= c2;
    s3_sum3_q     <= sum3;
    s3_sum9_q     <= sum9;
  end

  // stage 2: neighbour clipping and sums over the updated window
  assign c2       = win_q[1][1];
  assign lim_wide = {1'b0, c2} + {1'b0, cfg_i.thr};
  assign lim      = lim_wide[sblf_pkg::PIX_W] ? '1 : lim_wide[sblf_pkg::PIX_W-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        clip[i][j] = (win_q[i][j] > lim) ? c2 : win_q[i][j];
      end
      row_sum[i] = 10'(clip[i][0]) + 10'(clip[i][1]) + 10'(clip[i][2]);
    end
  end

  assign sum9 = 12'(row_sum[0]) + 12'(row_sum[1]) + 12'(row_sum[2]);
  assign sum3 = 10'(win_q[1][0]) + 10'(c2) + 10'(win_q[1][2]);

  // stage 3: truncating divides and mode selection
  assign prod3 = 21'(s3_sum3_q) * 21'(sblf_pkg::DIV3_MUL);
  assign prod9 = 25'(s3_sum9_q) * 25'(sblf_pkg::DIV9_MUL);
  assign mean  = prod3[sblf_pkg::DIV3_SHIFT +: sblf_pkg::PIX_W];
  assign div9  = prod9[sblf_pkg::DIV9_SHIFT +: sblf_pkg::PIX_W];

  always_comb begin
    res_pix = s3_c_q;
    if (!s3_col_edge_q) begin
      case (cfg_i.mode)
        sblf_pkg::MODE_MEAN:   res_pix = mean;
        sblf_pkg::MODE_THRESH: res_pix = (s3_c_q > cfg_i.thr) ? mean : s3_c_q;
        sblf_pkg::MODE_SELECT: res_pix = s3_row_edge_q ? s3_c_q : div9;
        default:               res_pix = s3_c_q;
      endcase
    end
  end

  assign res_o.valid = s3_valid_q;
  assign res_o.eof   = s3_eof_q;
  assign res_o.pix   = res_pix;

  assign inflight_o = sblf_pkg::FLIGHT_W'(s1_q.valid && s1_q.emit)
                    + sblf_pkg::FLIGHT_W'(s2_valid_q)
                    + sblf_pkg::FLIGHT_W'(s3_valid_q);

endmodule

>>> hw/rtl/sblf_outq.sv
// sblf_outq: small result queue that parts the filter pipeline from the output stream
// depends on sblf_pkg
module sblf_outq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sblf_pkg::result_t                 res_i,
  input  logic                              pop_i,
  output logic                              valid_o,
  output logic [sblf_pkg::PIX_W-1:0]        pix_o,
  output logic                              eof_o,
  output logic [sblf_pkg::OQ_CNT_W-1:0]     count_o
);

  logic [sblf_pkg::PIX_W:0]    data_q [sblf_pkg::OQ_DEPTH];
  logic [sblf_pkg::OQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [sblf_pkg::OQ_CNT_W-1:0] count_q;
  logic                          pop;

  assign pop = pop_i && (count_q != '0);

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      data_q[wr_ptr_q] <= {res_i.eof, res_i.pix};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (res_i.valid) begin
        wr_ptr_q <= wr_ptr_q + sblf_pkg::OQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + sblf_pkg::OQ_PTR_W'(1);
      end
      count_q <= count_q + sblf_pkg::OQ_CNT_W'(res_i.valid) - sblf_pkg::OQ_CNT_W'(pop);
    end
  end

  assign valid_o = (count_q != '0);
  assign pix_o   = data_q[rd_ptr_q][sblf_pkg::PIX_W-1:0];
  assign eof_o   = data_q[rd_ptr_q][sblf_pkg::PIX_W];
  assign count_o = count_q;

endmodule

>>> hw/rtl/sblf_checker.sv
// sblf_checker: port-level assertions for the selective blur luma filter, bound to the top
// uses only the stream handshake and payload ports of the top level
module sblf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output transfer withdrawn while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output payload changed while stalled");

  // input only backs up behind results waiting at the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

  // an output queue filling from empty comes from an earlier matching input transfer
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 4))
    else $error("result appeared without matching input transfer");

endmodule

bind selective_blur_luma_filter_unit sblf_checker u_sblf_checker (.*);

>>> tb/selective_blur_luma_filter_unit_tb.sv
// selective_blur_luma_filter_unit_tb: self-checking bench for the selective blur luma filter
// streams pixel and flush transfers under random back-pressure and checks every result
// against a cycle-free model of the filter; depends on sblf_pkg and the unit itself
module selective_blur_luma_filter_unit_tb;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 11;
  localparam int SETTLE_CYCLES   = 16;
  localparam int QUIET_LIMIT     = 4000;   // cycles without any transfer or register write before giving up
  localparam int HOLD_CYCLES     = 200;    // long receiver hold-off
  localparam int N_PHASES        = 24;
  localparam int ITEMS_PER_PHASE = 40;
  localparam int HOLD_PHASE_A    = 4;
  localparam int HOLD_PHASE_B    = 20;
  localparam int LONG_WIDTH      = 100;    // two lines of this width in one frame

  // one expected output transfer
  typedef struct packed {
    logic [sblf_pkg::PIX_W-1:0] pix;
    logic                       eof;
  } luma_out_t;

  // predicts the filtered stream and holds the results still owed by the block
  class luma_blur_scoreboard;
    logic [sblf_pkg::MODE_W-1:0]       mode;
    logic [sblf_pkg::PIX_W-1:0]        thr;
    logic [sblf_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [sblf_pkg::HEIGHT_REG_W-1:0] height_reg;
    logic [sblf_pkg::PIX_W-1:0]        row_above [sblf_pkg::MAX_WIDTH];
    logic [sblf_pkg::PIX_W-1:0]        row_now [sblf_pkg::MAX_WIDTH];
    logic [sblf_pkg::PIX_W-1:0]        win [3][3];
    int unsigned             next_col;
    int unsigned             out_pos;
    int unsigned             held;        // positions waiting in the pipeline
    int unsigned             held_real;   // waiting positions up to the newest real pixel
    luma_out_t               expected_q[$];
    int unsigned             mismatches;
    int unsigned             pixel_transfers;
    int unsigned             flush_transfers;
    int unsigned             results_checked;
    int unsigned             frames_closed;
    int unsigned             reg_writes;

    function new();
      foreach (row_above[i]) begin
        row_above[i] = '0;
        row_now[i]   = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      mode       = sblf_pkg::MODE_MEAN;
      thr        = sblf_pkg::PIX_W'(sblf_pkg::THR_RESET);
      width_reg  = sblf_pkg::WIDTH_REG_W'(sblf_pkg::WIDTH_RESET);
      height_reg = sblf_pkg::HEIGHT_REG_W'(sblf_pkg::HEIGHT_RESET);
      restart();
    endfunction

    function void restart();
      next_col  = 0;
      out_pos   = 0;
      held      = 0;
      held_real = 0;
    endfunction

    // sizes actually used: width held to 3..MAX_WIDTH, height to 1..MAX_HEIGHT
    function int unsigned active_width();
      if (width_reg < 3) return 3;
      if (width_reg > sblf_pkg::MAX_WIDTH) return sblf_pkg::MAX_WIDTH;
      return 32'(width_reg);
    endfunction

    function int unsigned active_height();
      if (height_reg < 1) return 1;
      if (height_reg > sblf_pkg::MAX_HEIGHT) return sblf_pkg::MAX_HEIGHT;
      return 32'(height_reg);
    endfunction

    function bit has_live();
      return held_real != 0;
    endfunction

    function void write_reg(sblf_pkg::reg_idx_e idx,
                            logic [sblf_pkg::CFG_DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        sblf_pkg::REG_MODE:      mode = data[sblf_pkg::MODE_W-1:0];
        sblf_pkg::REG_THRESHOLD: thr  = data[sblf_pkg::PIX_W-1:0];
        sblf_pkg::REG_FRAME_WIDTH: begin
          width_reg = data[sblf_pkg::WIDTH_REG_W-1:0];
          restart();
        end
        sblf_pkg::REG_FRAME_HEIGHT: begin
          height_reg = data[sblf_pkg::HEIGHT_REG_W-1:0];
          restart();
        end
        default: ;
      endcase
    endfunction

    // value of the centre pixel of the window once filtered
    function logic [sblf_pkg::PIX_W-1:0] filtered_centre(int unsigned w, int unsigned h);
      int unsigned col, row, c, mean, lim, sum, v;
      col  = out_pos % w;
      row  = out_pos / w;
      c    = 32'(win[1][1]);
      mean = (32'(win[1][0]) + c + 32'(win[1][2])) / 3;
      if (col == 0 || col == w - 1) return sblf_pkg::PIX_W'(c);
      case (mode)
        sblf_pkg::MODE_MEAN:   return sblf_pkg::PIX_W'(mean);
        sblf_pkg::MODE_THRESH: return sblf_pkg::PIX_W'((c > 32'(thr)) ? mean : c);
        sblf_pkg::MODE_SELECT: begin
          if (row == 0 || row == h - 1) return sblf_pkg::PIX_W'(c);
          // centre plus threshold saturates rather than wrapping
          lim = c + 32'(thr);
          if (lim > 255) lim = 255;
          sum = 0;
          foreach (win[i, j]) begin
            v = 32'(win[i][j]);
            sum += (v > lim) ? c : v;
          end
          return sblf_pkg::PIX_W'(sum / 9);
        end
        default: return sblf_pkg::PIX_W'(c);
      endcase
    endfunction

    // one position through line buffers and window; queues a result once the pipe is full
    function void predict_position(logic [sblf_pkg::PIX_W-1:0] pix, bit is_real);
      int unsigned w, h, col;
      bit          emit;
      luma_out_t   r;
      w   = active_width();
      h   = active_height();
      col = (next_col < w) ? next_col : 0;
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2]      = row_above[col];
      win[1][2]      = row_now[col];
      win[2][2]      = pix;
      row_above[col] = row_now[col];
      row_now[col]   = pix;
      next_col       = (col + 1 >= w) ? 0 : col + 1;
      emit = (held >= w + 1);
      if (!emit) held++;
      if (is_real) held_real = held;
      if (!emit) return;
      r.pix   = filtered_centre(w, h);
      r.eof   = (out_pos == w * h - 1);
      out_pos = r.eof ? 0 : out_pos + 1;
      expected_q.push_back(r);
      // the last real pixel has gone: next pixel starts a new frame at the top left
      if (!is_real) begin
        if (held_real > 0) held_real--;
        if (held_real == 0) restart();
      end
    endfunction

    function void note_transfer_in(logic cmd, logic [sblf_pkg::PIX_W-1:0] pix);
      if (cmd == sblf_pkg::CMD_PIXEL) begin
        pixel_transfers++;
        predict_position(pix, 1'b1);
      end else begin
        flush_transfers++;
        if (held_real != 0) predict_position('0, 1'b0);
      end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_transfer_out(logic [sblf_pkg::PIX_W-1:0] pix, logic eof);
      luma_out_t exp_r;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with none owed: pixel %0d end_of_frame %0b",
                                  pix, eof));
        return;
      end
      exp_r = expected_q.pop_front();
      if (pix !== exp_r.pix)
        report_mismatch($sformatf("result %0d pixel_out %0d, wanted %0d",
                                  results_checked, pix, exp_r.pix));
      if (eof !== exp_r.eof)
        report_mismatch($sformatf("result %0d end_of_frame %0b, wanted %0b",
                                  results_checked, eof, exp_r.eof));
      if (exp_r.eof) frames_closed++;
      results_checked++;
    endtask

    task close_out();
      if (expected_q.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
    endtask
  endclass

  logic                            clk          = 1'b0;
  logic                            rst_n        = 1'b0;
  logic                            cfg_we       = 1'b0;
  sblf_pkg::reg_idx_e              cfg_index    = sblf_pkg::REG_MODE;
  logic [sblf_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
  logic                            s_tvalid     = 1'b0;
  logic                            s_tready;
  logic [7:0]                      s_tdata      = '0;
  logic                            s_tuser      = sblf_pkg::CMD_PIXEL;
  logic                            m_tvalid;
  logic                            m_tready     = 1'b0;
  logic [7:0]                      m_tdata;
  logic                            m_tlast;

  luma_blur_scoreboard   sb = new();
  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;
  bit                    stall_request = 1'b0;
  int unsigned           phase_items;

  selective_blur_luma_filter_unit i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),    // [7:0] pixel_in
    .s_axis_tuser  (s_tuser),    // [0] command (1 = flush)
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),    // [7:0] pixel_out
    .m_axis_tlast  (m_tlast)     // end_of_frame
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // output side: random stalls, plus a long hold-off when asked, counted here
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        hold_left     = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // every accepted output transfer is checked against the oldest owed result
  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) sb.check_transfer_out(m_tdata, m_tlast);
  end

  // watchdog: too long without any transfer or register write ends the run
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("[%0t] no transfer for %0d cycles", $realtime, QUIET_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // idling profiles: sender light and receiver heavy, then swapped, then none
  task automatic set_idling(int profile);
    case (profile)
      0: begin
        send_idle_pct = 34;
        recv_idle_pct = 63;
      end
      1: begin
        send_idle_pct = 63;
        recv_idle_pct = 34;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // offer one input transfer, with random gaps in front, and wait for it to be taken
  task automatic send_item(logic cmd, logic [7:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= pix;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_transfer_in(cmd, pix);
    phase_items++;
  endtask

  task automatic send_pixels(int unsigned n);
    repeat (n) send_item(sblf_pkg::CMD_PIXEL, 8'($urandom));
  endtask

  // flush until the last real pixel has left; sometimes one spare flush that is dropped
  task automatic drain();
    while (sb.has_live()) send_item(sblf_pkg::CMD_FLUSH, 8'($urandom));
    if ($urandom_range(3) == 0) send_item(sblf_pkg::CMD_FLUSH, 8'($urandom));
  endtask

  // stop offering, wait for every owed result, then let the pipeline settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(sblf_pkg::reg_idx_e idx, logic [sblf_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // all four registers; spare upper data bits are random and must be ignored
  task automatic configure(logic [sblf_pkg::MODE_W-1:0] m, logic [sblf_pkg::PIX_W-1:0] t,
                           logic [sblf_pkg::WIDTH_REG_W-1:0] w,
                           logic [sblf_pkg::HEIGHT_REG_W-1:0] h);
    logic [sblf_pkg::CFG_DATA_W-1:0] d_mode, d_thr, d_width;
    d_mode                              = sblf_pkg::CFG_DATA_W'($urandom);
    d_mode[sblf_pkg::MODE_W-1:0]        = m;
    d_thr                               = sblf_pkg::CFG_DATA_W'($urandom);
    d_thr[sblf_pkg::PIX_W-1:0]          = t;
    d_width                             = sblf_pkg::CFG_DATA_W'($urandom);
    d_width[sblf_pkg::WIDTH_REG_W-1:0]  = w;
    cfg_write(sblf_pkg::REG_MODE, d_mode);
    cfg_write(sblf_pkg::REG_THRESHOLD, d_thr);
    cfg_write(sblf_pkg::REG_FRAME_WIDTH, d_width);
    cfg_write(sblf_pkg::REG_FRAME_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  // one random phase: mostly whole frames back to back, some cut short, some noise
  task automatic run_phase(int ph);
    logic [sblf_pkg::MODE_W-1:0]       m;
    logic [sblf_pkg::PIX_W-1:0]        t;
    logic [sblf_pkg::WIDTH_REG_W-1:0]  wr;
    logic [sblf_pkg::HEIGHT_REG_W-1:0] hr;
    int unsigned             frame_px, kind, n;
    m  = (ph < 8) ? sblf_pkg::MODE_W'(ph) : sblf_pkg::MODE_W'($urandom_range(7));
    t  = $urandom_range(1) ? sblf_pkg::PIX_W'($urandom_range(40))
                           : sblf_pkg::PIX_W'($urandom);
    wr = sblf_pkg::WIDTH_REG_W'($urandom_range(3, 12));
    hr = sblf_pkg::HEIGHT_REG_W'($urandom_range(1, 6));
    case (ph)
      1:  t = '0;                          // thresholded mean with the lowest threshold
      2:  t = '1;                          // selective mean with saturating limit
      3:  wr = '0;                         // width below range, held to three
      6: begin
        wr = sblf_pkg::WIDTH_REG_W'(2);
        hr = '0;                           // height below range, held to one
      end
      9:  hr = '1;                         // height above range, held to the maximum
      12: hr = sblf_pkg::HEIGHT_REG_W'(sblf_pkg::MAX_HEIGHT);
      14: wr = sblf_pkg::WIDTH_REG_W'(1);
      default: ;
    endcase
    wait_drained();
    set_idling(ph * 3 / N_PHASES);
    configure(m, t, wr, hr);
    frame_px = sb.active_width() * sb.active_height();
    if (ph == HOLD_PHASE_A || ph == HOLD_PHASE_B) stall_request = 1'b1;
    phase_items = 0;
    while (phase_items < ITEMS_PER_PHASE) begin
      kind = $urandom_range(99);
      if (kind < 70 && frame_px <= 200) begin
        send_pixels(frame_px);
      end else if (kind < 88) begin
        // frame ended early by flushing
        n = $urandom_range(1, (frame_px < 60) ? frame_px : 60);
        send_pixels(n);
        drain();
      end else begin
        // stray flushes mixed into the pixels
        repeat ($urandom_range(2, 10))
          send_item(($urandom_range(99) < 40) ? sblf_pkg::CMD_FLUSH : sblf_pkg::CMD_PIXEL,
                    8'($urandom));
      end
    end
    drain();
  endtask

  initial begin
    logic [7:0] corner_px [9];
    corner_px = '{8'd0, 8'd255, 8'd17, 8'd255, 8'd60, 8'd255, 8'd128, 8'd0, 8'd255};
    set_idling(0);
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: flush with nothing pending is dropped
    send_item(sblf_pkg::CMD_FLUSH, 8'hff);
    // 3x3 frame, selective mean, centre plus threshold above 255 must saturate
    wait_drained();
    configure(sblf_pkg::MODE_SELECT, 8'd200, sblf_pkg::WIDTH_REG_W'(3),
              sblf_pkg::HEIGHT_REG_W'(3));
    foreach (corner_px[i]) send_item(sblf_pkg::CMD_PIXEL, corner_px[i]);
    // drain the frame to its end_of_frame, then one more flush that finds nothing
    drain();
    send_item(sblf_pkg::CMD_FLUSH, 8'h00);
    // pixels after a partial flush keep the zero already pushed
    send_item(sblf_pkg::CMD_PIXEL, 8'hff);
    send_item(sblf_pkg::CMD_PIXEL, 8'h01);
    send_item(sblf_pkg::CMD_FLUSH, 8'haa);
    send_pixels(5);
    drain();

    // longer line: two full lines, results only after a line plus one, then drained
    wait_drained();
    configure(sblf_pkg::MODE_THRESH, 8'($urandom), sblf_pkg::WIDTH_REG_W'(LONG_WIDTH),
              sblf_pkg::HEIGHT_REG_W'(2));
    send_pixels(2 * LONG_WIDTH);
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) run_phase(ph);

    wait_drained();
    sb.close_out();
    $display("covered %0d pixel and %0d flush transfers across %0d register writes",
             sb.pixel_transfers, sb.flush_transfers, sb.reg_writes);
    $display("checked %0d results, %0d of them closing a frame",
             sb.results_checked, sb.frames_closed);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
